### design/irc_pkg.sv
// shared widths, constants and command types of the rgb rmse comparator
`default_nettype none

package irc_pkg;

    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 23;
    localparam int SQ_W     = 18;
    localparam int DEN_W    = 41;
    localparam int Q_W      = 33;
    localparam int ROOT_W   = 34;
    localparam int RMSE_W   = 17;
    localparam int THR_W    = 16;
    localparam int T2_W     = 32;
    localparam int STEP_W   = 5;
    localparam int AMP_W    = 12;

    localparam int MAX_PIXELS  = 4194304;
    localparam int COUNT_LIMIT = (MAX_PIXELS < 8388607) ? MAX_PIXELS : 8388607;

    localparam logic [CNT_W-1:0]  COUNT_CAP      = CNT_W'(COUNT_LIMIT);
    localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};
    localparam logic [17:0]       PER_PIXEL_FULL = 18'd195075;
    localparam logic [THR_W-1:0]  THR_RESET      = 16'd655;
    localparam logic [AMP_W-1:0]  AMP_GAIN       = 12'd10;
    localparam logic [AMP_W-1:0]  AMP_LIMIT      = 12'd255;
    localparam logic [Q_W-1:0]    SQRT_BIT_START = 33'h1_0000_0000;
    localparam logic [STEP_W-1:0] DIV_LAST       = 5'd31;
    localparam logic [STEP_W-1:0] SQRT_LAST      = 5'd16;

    typedef struct packed {
        logic load_pix;
        logic load_den;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic finish;
    } irc_cmd_t;

endpackage

`default_nettype wire

### design/irc_if.sv
// handshake channel interfaces for pixel pairs, results and the threshold write
`default_nettype none

interface irc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] golden_red;
    logic [7:0] golden_green;
    logic [7:0] golden_blue;
    logic [7:0] test_red;
    logic [7:0] test_green;
    logic [7:0] test_blue;
    logic       last_pixel;

    modport source (
        output valid, golden_red, golden_green, golden_blue,
               test_red, test_green, test_blue, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, golden_red, golden_green, golden_blue,
               test_red, test_green, test_blue, last_pixel,
        output ready
    );
endinterface

interface irc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  diff_red;
    logic [7:0]  diff_green;
    logic [7:0]  diff_blue;
    logic        frame_done;
    logic [16:0] rmse_value;
    logic        pass_flag;

    modport source (
        output valid, diff_red, diff_green, diff_blue, frame_done, rmse_value, pass_flag,
        input  ready
    );
    modport sink (
        input  valid, diff_red, diff_green, diff_blue, frame_done, rmse_value, pass_flag,
        output ready
    );
endinterface

interface irc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] rmse_threshold;

    modport source (
        output valid, rmse_threshold,
        input  ready
    );
    modport sink (
        input  valid, rmse_threshold,
        output ready
    );
endinterface

`default_nettype wire

### design/irc_ctrl.sv
// sequencing state machine of the rmse comparator
`default_nettype none

module irc_ctrl
    import irc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_last,
    output logic          in_ready,
    input  wire logic     out_ready,
    output logic          out_valid,
    output irc_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEN  = 3'd1;
    localparam logic [2:0] S_DIVI = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQI  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_set;
    logic              accept;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        out_set    = 1'b0;
        in_ready   = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        accept     = in_valid && in_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_pix = 1'b1;
                    if (in_last)
                        state_next = S_DEN;
                    else
                        out_set = 1'b1;
                end
            end
            S_DEN:
            begin
                cmd.load_den = 1'b1;
                state_next   = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                    state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == SQRT_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                out_set    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_set)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### design/irc_datapath.sv
// accumulators, restoring divider, square root unit and result word register
`default_nettype none

module irc_datapath
    import irc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire irc_cmd_t          cmd,
    input  wire logic              cfg_we,
    input  wire logic [THR_W-1:0]  cfg_data,
    input  wire logic [CHAN_W-1:0] golden_red,
    input  wire logic [CHAN_W-1:0] golden_green,
    input  wire logic [CHAN_W-1:0] golden_blue,
    input  wire logic [CHAN_W-1:0] test_red,
    input  wire logic [CHAN_W-1:0] test_green,
    input  wire logic [CHAN_W-1:0] test_blue,
    output logic [CHAN_W-1:0]      diff_red,
    output logic [CHAN_W-1:0]      diff_green,
    output logic [CHAN_W-1:0]      diff_blue,
    output logic                   frame_done,
    output logic [RMSE_W-1:0]      rmse_value,
    output logic                   pass_flag
);

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] t);
        return (g > t) ? (g - t) : (t - g);
    endfunction

    function automatic logic [CHAN_W-1:0] amplify(input logic [CHAN_W-1:0] d);
        logic [AMP_W-1:0] a;
        a = AMP_W'(d) * AMP_GAIN;
        return (a > AMP_LIMIT) ? CHAN_W'(AMP_LIMIT) : a[CHAN_W-1:0];
    endfunction

    logic [THR_W-1:0]  thr_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DEN_W-1:0]  den_reg;
    logic [T2_W-1:0]   t2_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic [Q_W-1:0]    x_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [Q_W-1:0]    bit_reg;

    logic [CHAN_W-1:0] d_red;
    logic [CHAN_W-1:0] d_green;
    logic [CHAN_W-1:0] d_blue;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    acc;

    logic              div0_ge;
    logic [DEN_W:0]    rem_shift;
    logic              div_ge;
    logic [DEN_W:0]    rem_sub;

    logic [ROOT_W:0]   trial;
    logic              sqrt_ge;
    logic              pass_now;

    logic [CHAN_W-1:0] diff_red_reg;
    logic [CHAN_W-1:0] diff_green_reg;
    logic [CHAN_W-1:0] diff_blue_reg;
    logic              frame_done_reg;
    logic [RMSE_W-1:0] rmse_reg;
    logic              pass_reg;

    always_comb
    begin
        d_red   = abs_diff(golden_red, test_red);
        d_green = abs_diff(golden_green, test_green);
        d_blue  = abs_diff(golden_blue, test_blue);
        sq      = SQ_W'(16'(d_red) * 16'(d_red))
                + SQ_W'(16'(d_green) * 16'(d_green))
                + SQ_W'(16'(d_blue) * 16'(d_blue));
        acc     = {1'b0, sum_reg} + (SUM_W + 1)'(sq);

        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.finish)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (cmd.load_pix && (count_reg < COUNT_CAP))
        begin
            sum_next   = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            count_next = count_reg + 1'b1;
        end

        // integer part of sum / den, then one quotient bit per step
        div0_ge   = {1'b0, sum_reg} >= den_reg;
        rem_shift = {rem_reg, 1'b0};
        div_ge    = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};

        trial     = {1'b0, root_reg} + (ROOT_W + 1)'(bit_reg);
        sqrt_ge   = {2'b0, x_reg} >= trial;

        pass_now  = (q_reg < Q_W'(t2_reg)) || ((q_reg == Q_W'(t2_reg)) && (rem_reg == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_den)
        begin
            den_reg <= DEN_W'(count_reg) * DEN_W'(PER_PIXEL_FULL);
            t2_reg  <= T2_W'(thr_reg) * T2_W'(thr_reg);
        end

        if (cmd.div_init)
        begin
            rem_reg <= div0_ge ? (DEN_W'(sum_reg) - den_reg) : DEN_W'(sum_reg);
            q_reg   <= Q_W'(div0_ge);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], div_ge};
        end

        if (cmd.sqrt_init)
        begin
            x_reg    <= q_reg;
            root_reg <= '0;
            bit_reg  <= SQRT_BIT_START;
        end
        else if (cmd.sqrt_step)
        begin
            if (sqrt_ge)
            begin
                x_reg    <= x_reg - trial[Q_W-1:0];
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        // result word
        if (cmd.load_pix)
        begin
            diff_red_reg   <= amplify(d_red);
            diff_green_reg <= amplify(d_green);
            diff_blue_reg  <= amplify(d_blue);
            frame_done_reg <= 1'b0;
            rmse_reg       <= '0;
            pass_reg       <= 1'b0;
        end
        else if (cmd.finish)
        begin
            frame_done_reg <= 1'b1;
            rmse_reg       <= root_reg[RMSE_W-1:0];
            pass_reg       <= pass_now;
        end
    end

    assign diff_red   = diff_red_reg;
    assign diff_green = diff_green_reg;
    assign diff_blue  = diff_blue_reg;
    assign frame_done = frame_done_reg;
    assign rmse_value = rmse_reg;
    assign pass_flag  = pass_reg;

endmodule

`default_nettype wire

### design/image_rmse_compare.sv
// top level of the rgb image rmse comparator
//
//  channel  modport  word
//  pixel    sink     golden and test rgb bytes, last_pixel
//  result   source   diff rgb bytes, frame_done, rmse_value, pass_flag
//  cfg      sink     rmse_threshold, always ready
//
// an ordinary pixel's result word is registered and valid in the cycle after acceptance
// the last pixel of a frame runs through denominator, divider init and steps, root init and steps, finish
// the next pixel is taken once the sequencer is idle and the result register is empty or being drained
// rst_n clears the sums, the count, the sequencer and sets the threshold to 655
// a stalled result holds the word and blocks further pixels
`default_nettype none

module image_rmse_compare
    import irc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    irc_pixel_if.sink     pixel,
    irc_result_if.source  result,
    irc_cfg_if.sink       cfg
);

    irc_cmd_t cmd;
    logic     cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    irc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_last   (pixel.last_pixel),
        .in_ready  (pixel.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    irc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg.rmse_threshold),
        .golden_red   (pixel.golden_red),
        .golden_green (pixel.golden_green),
        .golden_blue  (pixel.golden_blue),
        .test_red     (pixel.test_red),
        .test_green   (pixel.test_green),
        .test_blue    (pixel.test_blue),
        .diff_red     (result.diff_red),
        .diff_green   (result.diff_green),
        .diff_blue    (result.diff_blue),
        .frame_done   (result.frame_done),
        .rmse_value   (result.rmse_value),
        .pass_flag    (result.pass_flag)
    );

endmodule

`default_nettype wire
